@@ sv/dpor_pkg.sv @@
// ----------------------------------------------------------------------------
// dpor_pkg
// Shared constants for the disk pair overlap resolver.
// ----------------------------------------------------------------------------
package dpor_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;   // default centre width, Q15.8
  localparam int unsigned RADIUS_W        = 16;   // Q8.8 radius
  localparam int unsigned MAG_W           = 17;   // |dx|, |dy| once near
  localparam int unsigned RSUM_W          = 17;   // radius sum
  localparam int unsigned SQ_W            = 34;   // 17 x 17 square
  localparam int unsigned D2_W            = 35;   // sum of two squares
  localparam int unsigned FRAC_SHIFT      = 16;   // extra fraction bits of the radicand
  localparam int unsigned ROOT_W          = 25;   // dist, 16 fraction bits
  localparam int unsigned RAD_W           = 2 * ROOT_W; // sqrt radicand
  localparam int unsigned PEN_W           = 26;   // penetration depth
  localparam int unsigned PROD_W          = PEN_W + MAG_W;
  localparam int unsigned DEN_W           = ROOT_W + 2;  // dist or 2*dist
  localparam int unsigned NUM_W           = PROD_W + 2;  // 2*mag + den
  localparam int unsigned DIV_W           = DEN_W + 1;   // 2*den
  localparam int unsigned QUOT_W          = 19;   // push per axis
  localparam int unsigned FAR_LIMIT       = 131072;
  localparam int unsigned WIDE_W          = 34;   // headroom for adds

endpackage

@@ sv/dpor_sqrt.sv @@
// ----------------------------------------------------------------------------
// dpor_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module dpor_sqrt #(
  parameter int unsigned OUT_W = dpor_pkg::ROOT_W,
  parameter int unsigned IN_W  = 2 * OUT_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IN_W-1:0]  rad_i,
  output logic [OUT_W-1:0] root_o
);

  localparam int unsigned W = IN_W + 1;

  logic [W-1:0] rem_q  [OUT_W];
  logic [W-1:0] root_q [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    logic [W-1:0] rem_in, root_in, bit_c, trial, rem_d, root_d;

    if (s == 0) begin : g_first
      assign rem_in  = W'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign bit_c = W'(1) << (2 * (OUT_W - 1 - s));
    assign trial = root_in + bit_c;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + bit_c;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
      end
    end
  end

  assign root_o = root_q[OUT_W-1][OUT_W-1:0];

endmodule

@@ sv/dpor_div.sv @@
// ----------------------------------------------------------------------------
// dpor_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module dpor_div #(
  parameter int unsigned NUM_W  = dpor_pkg::NUM_W,
  parameter int unsigned DEN_W  = dpor_pkg::DIV_W,
  parameter int unsigned QUOT_W = dpor_pkg::QUOT_W
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned W = NUM_W + QUOT_W;

  logic [W-1:0]      rem_q  [QUOT_W];
  logic [DEN_W-1:0]  den_q  [QUOT_W];
  logic [QUOT_W-1:0] quot_q [QUOT_W];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    logic [W-1:0]      rem_in, shifted, rem_d;
    logic [DEN_W-1:0]  den_in;
    logic [QUOT_W-1:0] quot_in, quot_d;

    if (s == 0) begin : g_first
      assign rem_in  = W'(num_i);
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    assign shifted = W'(den_in) << (QUOT_W - 1 - s);

    always_comb begin
      rem_d  = rem_in;
      quot_d = quot_in;
      if (rem_in >= shifted) begin
        rem_d                    = rem_in - shifted;
        quot_d[QUOT_W - 1 - s]   = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_in;
        quot_q[s] <= quot_d;
      end
    end
  end

  assign quot_o = quot_q[QUOT_W-1];

endmodule

@@ sv/disk_pair_overlap_resolver_core.sv @@
// ----------------------------------------------------------------------------
// disk_pair_overlap_resolver_core
// Pushes two overlapping disks apart along their line of centres.
// ----------------------------------------------------------------------------
// One pair request enters per cycle while the pipeline advances. The pipeline
// holds the 25-stage square root of the squared centre distance
// and the 19-stage divider that scales the penetration onto each axis, plus
// three front stages, two stages around the penetration multiply and one
// output stage. The whole pipeline advances together: it holds while a result
// waits on the output and the downstream side is not ready, and moves
// otherwise, so a full pipeline streams one result per cycle. Ghost pairs,
// pairs apart, touching pairs and coincident centres pass through unchanged.
// ----------------------------------------------------------------------------
module disk_pair_overlap_resolver_core #(
  parameter int unsigned COORD_WIDTH = dpor_pkg::COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: first_x, first_y, second_x, second_y, first_radius, second_radius
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  logic [((4*COORD_WIDTH+2*16+7)/8)*8-1:0]   s_axis_tdata_i,
  // tuser: first_pinned, second_pinned, first_ghost, second_ghost
  input  logic [3:0]                                s_axis_tuser_i,
  // tdata: new_first_x, new_first_y, new_second_x, new_second_y
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]        m_axis_tdata_o,
  // tuser: pair_moved
  output logic [0:0]                                m_axis_tuser_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned RW    = dpor_pkg::RADIUS_W;
  localparam int unsigned MW    = dpor_pkg::MAG_W;
  localparam int unsigned WW    = dpor_pkg::WIDE_W;
  localparam int unsigned SQL   = dpor_pkg::ROOT_W;
  localparam int unsigned DVL   = dpor_pkg::QUOT_W;
  localparam int unsigned OUT_TW = ((4*CW+7)/8)*8;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic [MW-1:0]        adx;
    logic [MW-1:0]        ady;
    logic [dpor_pkg::RSUM_W-1:0] rsum;
    logic                 neg_x;
    logic                 neg_y;
    logic                 pin1;
    logic                 pin2;
    logic                 live;   // not ghost and near
    logic                 hit;    // overlap to resolve
  } side_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi, lo;
    hi = WW'(signed'({1'b0, {(CW-1){1'b1}}}));
    lo = -hi - WW'(1);
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Global advance: hold everything while the output is full and stalled.
  logic en;
  logic out_valid_q;
  assign en              = ~out_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = en;

  // ---------------- stage 1: differences, magnitudes, far test ------------
  logic signed [CW-1:0] in_x1, in_y1, in_x2, in_y2;
  logic [RW-1:0]        in_r1, in_r2;
  logic signed [DW-1:0] dx_c, dy_c;
  logic [DW-1:0]        adx_c, ady_c;
  logic                 near_c;
  side_t                s1_d, s1_q;
  logic                 v1_q;

  assign in_x1 = s_axis_tdata_i[0*CW +: CW];
  assign in_y1 = s_axis_tdata_i[1*CW +: CW];
  assign in_x2 = s_axis_tdata_i[2*CW +: CW];
  assign in_y2 = s_axis_tdata_i[3*CW +: CW];
  assign in_r1 = s_axis_tdata_i[4*CW +: RW];
  assign in_r2 = s_axis_tdata_i[4*CW+RW +: RW];

  assign dx_c  = DW'(in_x2) - DW'(in_x1);
  assign dy_c  = DW'(in_y2) - DW'(in_y1);
  assign adx_c = dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
  assign ady_c = dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
  assign near_c = (WW'(adx_c) < WW'(dpor_pkg::FAR_LIMIT))
               && (WW'(ady_c) < WW'(dpor_pkg::FAR_LIMIT));

  always_comb begin
    s1_d.x1    = in_x1;
    s1_d.y1    = in_y1;
    s1_d.x2    = in_x2;
    s1_d.y2    = in_y2;
    s1_d.adx   = adx_c[MW-1:0];
    s1_d.ady   = ady_c[MW-1:0];
    s1_d.rsum  = dpor_pkg::RSUM_W'(in_r1) + dpor_pkg::RSUM_W'(in_r2);
    s1_d.neg_x = dx_c[DW-1];
    s1_d.neg_y = dy_c[DW-1];
    s1_d.pin1  = s_axis_tuser_i[0];
    s1_d.pin2  = s_axis_tuser_i[1];
    s1_d.live  = near_c & ~s_axis_tuser_i[2] & ~s_axis_tuser_i[3];
    s1_d.hit   = 1'b0;
  end

  // ---------------- stage 2: squares ---------------------------------------
  logic [dpor_pkg::SQ_W-1:0] sqx_q, sqy_q, rsq_q;
  side_t                     s2_q;
  logic                      v2_q;

  // ---------------- stage 3: overlap test, radicand -------------------------
  logic [dpor_pkg::D2_W-1:0] d2_c;
  logic                      hit_c;
  logic [dpor_pkg::RAD_W-1:0] rad_q;
  side_t                     s3_d, s3_q;
  logic                      v3_q;

  assign d2_c  = dpor_pkg::D2_W'(sqx_q) + dpor_pkg::D2_W'(sqy_q);
  assign hit_c = s2_q.live && (d2_c <= dpor_pkg::D2_W'(rsq_q)) && (d2_c != '0);

  always_comb begin
    s3_d     = s2_q;
    s3_d.hit = hit_c;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      sqx_q <= dpor_pkg::SQ_W'(s1_q.adx) * dpor_pkg::SQ_W'(s1_q.adx);
      sqy_q <= dpor_pkg::SQ_W'(s1_q.ady) * dpor_pkg::SQ_W'(s1_q.ady);
      rsq_q <= dpor_pkg::SQ_W'(s1_q.rsum) * dpor_pkg::SQ_W'(s1_q.rsum);
      s2_q  <= s1_q;
      rad_q <= hit_c ? {d2_c[dpor_pkg::SQ_W-1:0], {dpor_pkg::FRAC_SHIFT{1'b0}}} : '0;
      s3_q  <= s3_d;
    end
  end

  // ---------------- square root, side data travels alongside ----------------
  logic [dpor_pkg::ROOT_W-1:0] dist_c;
  side_t                       lna_q [SQL];
  logic                        vla_q [SQL];

  dpor_sqrt #(
    .OUT_W (dpor_pkg::ROOT_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (dist_c)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      lna_q[0] <= s3_q;
      for (int i = 1; i < SQL; i++) lna_q[i] <= lna_q[i-1];
    end
  end

  // ---------------- stage 4: penetration ------------------------------------
  logic [dpor_pkg::PEN_W-1:0]  pen_q;
  logic [dpor_pkg::ROOT_W-1:0] dist_q;
  side_t                       s4_q;
  logic                        v4_q;

  // ---------------- stage 5: push magnitude, divisor ------------------------
  logic [dpor_pkg::PROD_W-1:0] magx_q, magy_q;
  logic [dpor_pkg::DEN_W-1:0]  den_q;
  side_t                       s5_q;
  logic                        v5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pen_q  <= (dpor_pkg::PEN_W'(lna_q[SQL-1].rsum) << 8) - dpor_pkg::PEN_W'(dist_c);
      dist_q <= dist_c;
      s4_q   <= lna_q[SQL-1];
      magx_q <= dpor_pkg::PROD_W'(pen_q) * dpor_pkg::PROD_W'(s4_q.adx);
      magy_q <= dpor_pkg::PROD_W'(pen_q) * dpor_pkg::PROD_W'(s4_q.ady);
      // whole push to one disk divides by dist, a half push by 2*dist
      den_q  <= (s4_q.pin1 | s4_q.pin2) ? dpor_pkg::DEN_W'(dist_q)
                                        : dpor_pkg::DEN_W'(dist_q) << 1;
      s5_q   <= s4_q;
    end
  end

  // ---------------- rounding division per axis ------------------------------
  logic [dpor_pkg::NUM_W-1:0]  numx_c, numy_c;
  logic [dpor_pkg::DIV_W-1:0]  div_c;
  logic [dpor_pkg::QUOT_W-1:0] qx_c, qy_c;
  side_t                       lnb_q [DVL];
  logic                        vlb_q [DVL];

  // round to nearest, ties away: floor((2*mag + den) / (2*den))
  assign numx_c = (dpor_pkg::NUM_W'(magx_q) << 1) + dpor_pkg::NUM_W'(den_q);
  assign numy_c = (dpor_pkg::NUM_W'(magy_q) << 1) + dpor_pkg::NUM_W'(den_q);
  assign div_c  = dpor_pkg::DIV_W'(den_q) << 1;

  dpor_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numx_c),
    .den_i  (div_c),
    .quot_o (qx_c)
  );

  dpor_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numy_c),
    .den_i  (div_c),
    .quot_o (qy_c)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      lnb_q[0] <= s5_q;
      for (int i = 1; i < DVL; i++) lnb_q[i] <= lnb_q[i-1];
    end
  end

  // ---------------- stage 6: apply push, saturate ---------------------------
  side_t                fin;
  logic signed [WW-1:0] px_c, py_c;
  logic                 mv1_c, mv2_c;
  logic signed [CW-1:0] n_x1, n_y1, n_x2, n_y2;
  logic                 moved_c;

  assign fin   = lnb_q[DVL-1];
  assign px_c  = fin.neg_x ? -WW'(qx_c) : WW'(qx_c);
  assign py_c  = fin.neg_y ? -WW'(qy_c) : WW'(qy_c);
  // first pinned sends all to the second, also when both are pinned
  assign mv1_c = fin.hit & ~fin.pin1;
  assign mv2_c = fin.hit & (fin.pin1 | ~fin.pin2);

  assign n_x1 = mv1_c ? sat(WW'(fin.x1) - px_c) : fin.x1;
  assign n_y1 = mv1_c ? sat(WW'(fin.y1) - py_c) : fin.y1;
  assign n_x2 = mv2_c ? sat(WW'(fin.x2) + px_c) : fin.x2;
  assign n_y2 = mv2_c ? sat(WW'(fin.y2) + py_c) : fin.y2;
  assign moved_c = (n_x1 != fin.x1) || (n_y1 != fin.y1)
                || (n_x2 != fin.x2) || (n_y2 != fin.y2);

  logic [OUT_TW-1:0] out_data_q;
  logic              out_moved_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q  <= OUT_TW'({n_y2, n_x2, n_y1, n_x1});
      out_moved_q <= moved_c;
    end
  end

  // ---------------- valid bits, advanced with the data ----------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SQL; i++) vla_q[i] <= 1'b0;
      for (int i = 0; i < DVL; i++) vlb_q[i] <= 1'b0;
    end else if (en) begin
      v1_q     <= s_axis_tvalid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      vla_q[0] <= v3_q;
      for (int i = 1; i < SQL; i++) vla_q[i] <= vla_q[i-1];
      v4_q     <= vla_q[SQL-1];
      v5_q     <= v4_q;
      vlb_q[0] <= v5_q;
      for (int i = 1; i < DVL; i++) vlb_q[i] <= vlb_q[i-1];
      out_valid_q <= vlb_q[DVL-1];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_moved_q;

endmodule
